// ----- src/bchd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bchd_pkg
// shared types and constants of the button click and hold detector
// ----------------------------------------------------------------------------
package bchd_pkg;

	localparam int unsigned BUTTONS     = 4;
	localparam int unsigned BTN_W       = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
	localparam int unsigned MAX_RESULTS = 4;
	localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int unsigned LEVEL_BITS  = 4;
	localparam int unsigned OUT_BTN_W   = 2;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [7:0]  DEBOUNCE_RESET  = 8'd30;
	localparam logic [15:0] THRESHOLD_RESET = 16'd500;
	localparam logic [7:0]  CLICK_MAX       = 8'hFF;

	localparam logic FUNC_EDGE  = 1'b0;
	localparam logic FUNC_SCAN  = 1'b1;
	localparam logic KIND_CLICK = 1'b0;
	localparam logic KIND_HOLD  = 1'b1;

	typedef enum logic [0:0] {
		CFG_DEBOUNCE  = 1'b0,
		CFG_THRESHOLD = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EDGE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [7:0]  debounce_ms;
		logic [15:0] threshold_ms;
	} cfg_t;

	typedef struct packed {
		logic ge;
		logic eq;
	} cmp_t;

	typedef struct packed {
		logic [OUT_BTN_W-1:0] event_button;
		logic                 event_kind;
		logic [7:0]           click_total;
		logic [6:0]           hold_level;
	} result_t;

endpackage
`default_nettype wire

// ----- src/bchd_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bchd_req_if
// request channel: edge events and periodic scans
// ----------------------------------------------------------------------------
interface bchd_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [3:0]  button_index;
	logic        edge_pressed;
	logic [3:0]  level_mask;
	logic [31:0] now_ms;

	modport source (
		output valid, func, button_index, edge_pressed, level_mask, now_ms,
		input  ready
	);
	modport sink (
		input  valid, func, button_index, edge_pressed, level_mask, now_ms,
		output ready
	);
endinterface
`default_nettype wire

// ----- src/bchd_evt_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bchd_evt_if
// event channel: click sequence and hold results
// ----------------------------------------------------------------------------
interface bchd_evt_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_button;
	logic       event_kind;
	logic [7:0] click_total;
	logic [6:0] hold_level;
	logic       last_event;

	modport source (
		output valid, event_button, event_kind, click_total, hold_level, last_event,
		input  ready
	);
	modport sink (
		input  valid, event_button, event_kind, click_total, hold_level, last_event,
		output ready
	);
endinterface
`default_nettype wire

// ----- src/bchd_cmp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bchd_cmp
// shared elapsed-time unit: wrapping subtract and compare against a limit
// ----------------------------------------------------------------------------
module bchd_cmp (
	input  wire logic [31:0]   now_ms,
	input  wire logic [31:0]   stamp,
	input  wire logic [15:0]   limit,
	output bchd_pkg::cmp_t     res
);

	logic [31:0] elapsed;

	assign elapsed = now_ms - stamp;
	assign res.ge  = (elapsed >= {16'd0, limit});
	assign res.eq  = (elapsed == {16'd0, limit});

endmodule
`default_nettype wire

// ----- src/bchd_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bchd_ctrl
// sequencer, per-button state and result registers
// ----------------------------------------------------------------------------
module bchd_ctrl (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  bchd_pkg::cfg_t  cfg,
	bchd_req_if.sink        req_in,
	bchd_evt_if.source      evt_out
);

	localparam int unsigned BTN_W = bchd_pkg::BTN_W;
	localparam int unsigned CNT_W = bchd_pkg::CNT_W;

	bchd_pkg::state_t state_q, state_d;

	logic        edge_press_q;
	logic [3:0]  idx_q;
	logic [3:0]  levels_q;
	logic [31:0] now_q;
	logic [BTN_W-1:0] scan_q;
	logic [CNT_W-1:0] n_q;

	logic [7:0]  click_q   [bchd_pkg::BUTTONS];
	logic [7:0]  hold_q    [bchd_pkg::BUTTONS];
	logic [31:0] press_q   [bchd_pkg::BUTTONS];
	logic [31:0] release_q [bchd_pkg::BUTTONS];

	logic               pend_valid_q;
	bchd_pkg::result_t  pend_q;
	logic               out_valid_q;
	logic               out_last_q;
	bchd_pkg::result_t  out_q;

	logic [BTN_W-1:0]  addr;
	logic              down;
	logic [31:0]       stamp;
	logic [15:0]       limit;
	bchd_pkg::cmp_t    cmp;
	logic              ev_hold, ev_click, ev;
	logic              out_free;
	logic              accept, start_edge, start_scan;
	logic              step, push_out, flush_move;
	logic              last_btn, limit_hit;
	logic              idx_ok;
	logic [7:0]        hold_inc;
	bchd_pkg::result_t new_res;

	assign accept     = req_in.valid && req_in.ready;
	assign start_edge = accept && (req_in.func == bchd_pkg::FUNC_EDGE);
	assign start_scan = accept && (req_in.func == bchd_pkg::FUNC_SCAN);

	// edges for buttons past the button count leave the state alone
	assign idx_ok = ({1'b0, idx_q} < 5'(bchd_pkg::BUTTONS));

	assign addr = (state_q == bchd_pkg::ST_EDGE) ? BTN_W'(idx_q) : scan_q;

	always_comb begin
		down = 1'b0;
		for (int k = 0; k < bchd_pkg::LEVEL_BITS; k++) begin
			if (k < bchd_pkg::BUTTONS && scan_q == BTN_W'(k)) begin
				down = levels_q[k];
			end
		end
	end

	// one elapsed-time compare per cycle, shared by edge and scan work
	assign stamp = ((state_q == bchd_pkg::ST_EDGE) || down) ? press_q[addr] : release_q[addr];
	assign limit = (state_q == bchd_pkg::ST_EDGE) ? {8'd0, cfg.debounce_ms} : cfg.threshold_ms;

	bchd_cmp u_cmp (
		.now_ms (now_q),
		.stamp  (stamp),
		.limit  (limit),
		.res    (cmp)
	);

	assign hold_inc = hold_q[addr] + 8'd1;
	assign ev_hold  = down && cmp.ge;
	assign ev_click = !down && (click_q[addr] != 8'd0) && cmp.ge;
	assign ev       = ev_hold || ev_click;

	always_comb begin
		new_res.event_button = bchd_pkg::OUT_BTN_W'(addr);
		new_res.event_kind   = ev_hold ? bchd_pkg::KIND_HOLD : bchd_pkg::KIND_CLICK;
		new_res.click_total  = ev_hold ? 8'd0 : click_q[addr];
		new_res.hold_level   = ev_hold ? hold_inc[7:1] : hold_q[addr][7:1];
	end

	assign out_free  = !out_valid_q || evt_out.ready;
	assign last_btn  = (scan_q == BTN_W'(bchd_pkg::BUTTONS - 1));
	assign limit_hit = ev && ((n_q + CNT_W'(1)) == CNT_W'(bchd_pkg::MAX_RESULTS));

	always_comb begin
		state_d    = state_q;
		step       = 1'b0;
		flush_move = 1'b0;
		unique case (state_q)
			bchd_pkg::ST_IDLE: begin
				if (start_edge) begin
					state_d = bchd_pkg::ST_EDGE;
				end else if (start_scan) begin
					state_d = bchd_pkg::ST_SCAN;
				end
			end
			bchd_pkg::ST_EDGE: begin
				state_d = bchd_pkg::ST_IDLE;
			end
			bchd_pkg::ST_SCAN: begin
				// a new result needs the pending slot moved out first
				if (!(ev && pend_valid_q && !out_free)) begin
					step = 1'b1;
					if (last_btn || limit_hit) begin
						state_d = bchd_pkg::ST_FLUSH;
					end
				end
			end
			bchd_pkg::ST_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = bchd_pkg::ST_IDLE;
				end else if (out_free) begin
					flush_move = 1'b1;
					state_d    = bchd_pkg::ST_IDLE;
				end
			end
			default: state_d = bchd_pkg::ST_IDLE;
		endcase
	end

	assign push_out = (step && ev && pend_valid_q) || flush_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bchd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			edge_press_q <= req_in.edge_pressed;
			idx_q        <= req_in.button_index;
			levels_q     <= req_in.level_mask;
			now_q        <= req_in.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			n_q    <= '0;
		end else if (start_scan) begin
			scan_q <= '0;
			n_q    <= '0;
		end else if (step) begin
			if (!last_btn) begin
				scan_q <= scan_q + BTN_W'(1);
			end
			if (ev) begin
				n_q <= n_q + CNT_W'(1);
			end
		end
	end

	// per-button state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < bchd_pkg::BUTTONS; b++) begin
				click_q[b]   <= '0;
				hold_q[b]    <= '0;
				press_q[b]   <= '0;
				release_q[b] <= '0;
			end
		end else if (state_q == bchd_pkg::ST_EDGE) begin
			if (idx_ok) begin
				if (edge_press_q) begin
					if (click_q[addr] != bchd_pkg::CLICK_MAX) begin
						click_q[addr] <= click_q[addr] + 8'd1;
					end
					press_q[addr] <= now_q;
				end else begin
					release_q[addr] <= now_q;
					if ((!cmp.ge || cmp.eq) && click_q[addr] != 8'd0) begin
						click_q[addr] <= click_q[addr] - 8'd1;
					end
				end
			end
		end else if (step && ev) begin
			click_q[addr] <= 8'd0;
			if (ev_hold) begin
				press_q[addr] <= now_q;
				hold_q[addr]  <= hold_inc;
			end
		end
	end

	// pending result waits until it is known whether it is the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (step && ev) begin
			pend_valid_q <= 1'b1;
		end else if (flush_move) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && ev) begin
			pend_q <= new_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_out) begin
			out_valid_q <= 1'b1;
		end else if (evt_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_out) begin
			out_q      <= pend_q;
			out_last_q <= flush_move;
		end
	end

	assign req_in.ready         = (state_q == bchd_pkg::ST_IDLE);
	assign evt_out.valid        = out_valid_q;
	assign evt_out.event_button = out_q.event_button;
	assign evt_out.event_kind   = out_q.event_kind;
	assign evt_out.click_total  = out_q.click_total;
	assign evt_out.hold_level   = out_q.hold_level;
	assign evt_out.last_event   = out_last_q;

endmodule
`default_nettype wire

// ----- src/button_click_hold_detector.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_click_hold_detector
// multi-click and long-press detection for a small set of buttons
// ----------------------------------------------------------------------------
// Edge requests (func 0) update one button's click count and press or release
// stamp and produce no event; after the request is accepted the update is made
// in the ST_EDGE state. Scan requests (func 1) visit the buttons one per cycle through
// a single elapsed-time compare unit, pausing while a new event meets a full
// pending slot and an output register not yet taken, and then end in ST_FLUSH.
// Each event is kept one slot back so the final event of a scan can carry
// last_event; the block takes no request until the final event of a scan has
// moved into the output register. Configuration writes are taken at any time
// and should be made only while the block is idle.
// ----------------------------------------------------------------------------
module button_click_hold_detector (
	input  wire logic         clk,
	input  wire logic         arst_n,
	bchd_req_if.sink          req_in,
	bchd_evt_if.source        evt_out,
	input  wire logic         cfg_we,
	input  wire logic [0:0]   cfg_index,
	input  wire logic [bchd_pkg::CFG_DATA_W-1:0] cfg_data
);

	bchd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms  <= bchd_pkg::DEBOUNCE_RESET;
			cfg_q.threshold_ms <= bchd_pkg::THRESHOLD_RESET;
		end else if (cfg_we) begin
			unique case (bchd_pkg::cfg_idx_t'(cfg_index))
				bchd_pkg::CFG_DEBOUNCE:  cfg_q.debounce_ms  <= cfg_data[7:0];
				bchd_pkg::CFG_THRESHOLD: cfg_q.threshold_ms <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	bchd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.req_in  (req_in),
		.evt_out (evt_out)
	);

endmodule
`default_nettype wire

// ----- src/bchd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bchd_checker
// port-level checks of the button click and hold detector
// ----------------------------------------------------------------------------
module bchd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_ready,
	input wire logic       req_func,
	input wire logic       evt_valid,
	input wire logic       evt_ready,
	input wire logic [1:0] evt_button,
	input wire logic       evt_kind,
	input wire logic [7:0] evt_clicks,
	input wire logic [6:0] evt_hold,
	input wire logic       evt_last
);

	// an accepted request makes the block busy, so ready drops
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready stayed high after a request");

	// edge requests never raise an event
	a_edge_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_func == bchd_pkg::FUNC_EDGE && !evt_valid
		|=> !evt_valid)
		else $error("event raised by an edge request");

	// hold events carry no clicks, click events carry at least one
	a_kind_clicks: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid |-> ((evt_kind == bchd_pkg::KIND_HOLD) == (evt_clicks == 8'd0)))
		else $error("click total does not match event kind");

	a_evt_stable: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready
		|=> evt_valid && $stable({evt_button, evt_kind, evt_clicks, evt_hold, evt_last}))
		else $error("stalled event changed");

endmodule

bind button_click_hold_detector bchd_checker u_bchd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req_in.valid),
	.req_ready  (req_in.ready),
	.req_func   (req_in.func),
	.evt_valid  (evt_out.valid),
	.evt_ready  (evt_out.ready),
	.evt_button (evt_out.event_button),
	.evt_kind   (evt_out.event_kind),
	.evt_clicks (evt_out.click_total),
	.evt_hold   (evt_out.hold_level),
	.evt_last   (evt_out.last_event)
);
`default_nettype wire

// ----- sim/button_click_hold_detector_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_hold_detector_test
// Self-checking bench for the button click and hold detector. A table of
// edge and scan requests runs first, a few rows with their events typed in.
// Five register settings with random press, release and scan sequences
// follow. Both channels idle at random and the event side holds off once so
// that the block fills up. Every event is checked field by field against a
// behavioral model kept in the bench.
// ----------------------------------------------------------------------------
module button_click_hold_detector_test;

	localparam int unsigned BUTTONS         = bchd_pkg::BUTTONS;
	localparam int unsigned LEVEL_BITS      = bchd_pkg::LEVEL_BITS;
	localparam int unsigned MAX_RESULTS     = bchd_pkg::MAX_RESULTS;
	localparam int unsigned OUT_BTN_W       = bchd_pkg::OUT_BTN_W;
	localparam int unsigned CFG_DATA_W      = bchd_pkg::CFG_DATA_W;
	localparam logic [7:0]  CLICK_MAX       = bchd_pkg::CLICK_MAX;
	localparam logic [7:0]  DEBOUNCE_RESET  = bchd_pkg::DEBOUNCE_RESET;
	localparam logic [15:0] THRESHOLD_RESET = bchd_pkg::THRESHOLD_RESET;
	localparam logic        FUNC_EDGE       = bchd_pkg::FUNC_EDGE;
	localparam logic        FUNC_SCAN       = bchd_pkg::FUNC_SCAN;
	localparam logic        KIND_CLICK      = bchd_pkg::KIND_CLICK;
	localparam logic        KIND_HOLD       = bchd_pkg::KIND_HOLD;

	localparam int unsigned HOLD_OFF_CYCLES = 200;
	localparam int unsigned WATCHDOG_LIMIT  = 2000;
	localparam int unsigned SETTLE_CYCLES   = 12;
	localparam int unsigned DRAIN_CYCLES    = 20;
	localparam int unsigned PHASE_ITEMS     = 38;
	localparam int unsigned MAX_REPORTS     = 40;
	localparam int          NOT_TYPED       = -1;

	typedef struct packed {
		logic        func;
		logic [3:0]  button;
		logic        pressed;
		logic [3:0]  levels;
		logic [31:0] now;
	} btn_req_t;

	typedef struct packed {
		bchd_pkg::result_t body;
		logic              last;
	} btn_evt_t;

	typedef struct {
		btn_req_t req;
		int       typed_count;
		btn_evt_t typed_evt;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [0:0]            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bchd_req_if req_bus ();
	bchd_evt_if evt_bus ();

	button_click_hold_detector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_in    (req_bus),
		.evt_out   (evt_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// detector state as the bench sees it
	logic [7:0]  debounce_cfg;
	logic [15:0] threshold_cfg;
	logic [7:0]  click_tally   [BUTTONS];
	logic [7:0]  hold_tally    [BUTTONS];
	logic [31:0] press_stamp   [BUTTONS];
	logic [31:0] release_stamp [BUTTONS];

	btn_evt_t    events_due [$];
	stim_row_t   stim_rows [$];
	btn_evt_t    want_evt;

	int unsigned errors;
	int unsigned scans_sent;
	int unsigned edges_sent;
	int unsigned events_checked;
	int unsigned cfg_writes;
	int unsigned quiet_cycles;
	bit          no_idle;
	bit          hold_off_pending;
	logic [31:0] clock_ms;
	logic [3:0]  down_mask;

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (no_idle)
			return 0;
		roll = $urandom_range(0, 19);
		if (roll < 10)
			return 0;
		if (roll < 18)
			return $urandom_range(1, 3);
		return $urandom_range(15, 50);
	endfunction

	// updates the state for one request and queues the events it raises
	function automatic int detect_events(input btn_req_t r);
		btn_evt_t    scan_evts [$];
		btn_evt_t    ev;
		logic [31:0] span;
		int unsigned i;
		int unsigned b;
		logic        down;
		b = r.button;
		if (r.func == FUNC_EDGE) begin
			if (b < BUTTONS) begin
				if (r.pressed) begin
					if (click_tally[b] != CLICK_MAX)
						click_tally[b] = click_tally[b] + 8'd1;
					press_stamp[b] = r.now;
				end else begin
					release_stamp[b] = r.now;
					span = r.now - press_stamp[b];
					if (span <= {24'd0, debounce_cfg} && click_tally[b] != 8'd0)
						click_tally[b] = click_tally[b] - 8'd1;
				end
			end
			return 0;
		end
		i = 0;
		while (i < BUTTONS && scan_evts.size() < MAX_RESULTS) begin
			down = (i < LEVEL_BITS) && r.levels[i];
			ev = '0;
			ev.body.event_button = i[OUT_BTN_W-1:0];
			if (down) begin
				span = r.now - press_stamp[i];
				if (span >= {16'd0, threshold_cfg}) begin
					press_stamp[i] = r.now;
					hold_tally[i] = hold_tally[i] + 8'd1;
					click_tally[i] = 8'd0;
					ev.body.event_kind = KIND_HOLD;
					ev.body.hold_level = hold_tally[i][7:1];
					scan_evts.push_back(ev);
				end
			end else if (click_tally[i] != 8'd0) begin
				span = r.now - release_stamp[i];
				if (span >= {16'd0, threshold_cfg}) begin
					ev.body.event_kind = KIND_CLICK;
					ev.body.click_total = click_tally[i];
					ev.body.hold_level = hold_tally[i][7:1];
					click_tally[i] = 8'd0;
					scan_evts.push_back(ev);
				end
			end
			i++;
		end
		if (scan_evts.size() != 0)
			scan_evts[scan_evts.size() - 1].last = 1'b1;
		foreach (scan_evts[k])
			events_due.push_back(scan_evts[k]);
		return scan_evts.size();
	endfunction

	function automatic void add_row(input logic func, input logic [3:0] button,
			input logic pressed, input logic [3:0] levels, input logic [31:0] now,
			input int typed_count, input logic [1:0] ebtn, input logic ekind,
			input logic [7:0] clicks, input logic [6:0] level);
		stim_row_t row;
		row.req = {func, button, pressed, levels, now};
		row.typed_count = typed_count;
		row.typed_evt = {ebtn, ekind, clicks, level, typed_count > 0};
		stim_rows.push_back(row);
	endfunction

	// valid stays high on return; pause_req lowers it when a gap follows
	task automatic send_req(input btn_req_t r, output int produced);
		req_bus.valid        <= 1'b1;
		req_bus.func         <= r.func;
		req_bus.button_index <= r.button;
		req_bus.edge_pressed <= r.pressed;
		req_bus.level_mask   <= r.levels;
		req_bus.now_ms       <= r.now;
		@(posedge clk);
		while (req_bus.ready !== 1'b1)
			@(posedge clk);
		produced = detect_events(r);
		if (r.func == FUNC_SCAN)
			scans_sent++;
		else
			edges_sent++;
	endtask

	task automatic pause_req();
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_register(input bchd_pkg::cfg_idx_t idx,
			input logic [CFG_DATA_W-1:0] value);
		req_bus.valid <= 1'b0;
		while (events_due.size() != 0)
			@(posedge clk);
		// an edge or empty scan may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == bchd_pkg::CFG_DEBOUNCE)
			debounce_cfg = value[7:0];
		else
			threshold_cfg = value[15:0];
		cfg_writes++;
	endtask

	task automatic run_phase(input logic [7:0] debounce, input logic [15:0] threshold,
			input bit pressure);
		btn_req_t    item;
		int          produced;
		int unsigned k;
		int unsigned roll;
		int unsigned b;
		int unsigned thr;
		write_register(bchd_pkg::CFG_DEBOUNCE, {8'd0, debounce});
		write_register(bchd_pkg::CFG_THRESHOLD, threshold);
		clock_ms = $urandom();
		down_mask = '0;
		thr = threshold_cfg;
		for (k = 0; k < PHASE_ITEMS; k++) begin
			no_idle = (k < PHASE_ITEMS / 5);
			roll = $urandom_range(0, 19);
			item = '0;
			if (roll < 2) begin
				// noise: any field value
				item.func    = 1'($urandom_range(0, 1));
				item.button  = 4'($urandom_range(0, 15));
				item.pressed = 1'($urandom_range(0, 1));
				item.levels  = 4'($urandom_range(0, 15));
				item.now     = $urandom();
			end else if (roll < 11) begin
				b = $urandom_range(0, BUTTONS - 1);
				clock_ms = clock_ms + $urandom_range(0, 2 * debounce_cfg + 4);
				item.func    = FUNC_EDGE;
				item.button  = 4'(b);
				item.pressed = !down_mask[b];
				// repeated edge in the same direction
				if (roll == 2)
					item.pressed = down_mask[b];
				down_mask[b] = item.pressed;
				item.now     = clock_ms;
			end else begin
				clock_ms = clock_ms + $urandom_range(0, thr + thr / 2 + 4);
				item.func   = FUNC_SCAN;
				item.levels = down_mask;
				if (roll == 19) begin
					b = $urandom_range(0, LEVEL_BITS - 1);
					item.levels[b] = ~item.levels[b];
				end
				item.now = clock_ms;
			end
			send_req(item, produced);
			pause_req();
		end
		no_idle = 1'b0;
		if (pressure) begin
			// event side stalls while full scans keep coming
			hold_off_pending = 1'b1;
			for (k = 0; k < 6; k++) begin
				clock_ms = clock_ms + 32'd3;
				item = '0;
				item.func   = FUNC_SCAN;
				item.levels = 4'hF;
				item.now    = clock_ms;
				send_req(item, produced);
			end
			pause_req();
		end
	endtask

	// event side: ready with random stalls
	initial begin
		int unsigned stall;
		evt_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				evt_bus.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				evt_bus.ready <= 1'b1;
			end else begin
				stall = pick_gap();
				if (stall != 0) begin
					evt_bus.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				evt_bus.ready <= 1'b1;
			end
		end
	end

	// event check and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_bus.valid && req_bus.ready) || (evt_bus.valid && evt_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: nothing moved for %0d cycles", quiet_cycles);
				$display("== FAIL ==");
				$finish;
			end
			if (evt_bus.valid === 1'b1 && evt_bus.ready === 1'b1) begin
				events_checked++;
				if (events_due.size() == 0) begin
					report_mismatch($sformatf("event from button %0d with none expected",
						evt_bus.event_button));
				end else begin
					want_evt = events_due.pop_front();
					if (evt_bus.event_button !== want_evt.body.event_button)
						report_mismatch($sformatf("event_button got %0d want %0d",
							evt_bus.event_button, want_evt.body.event_button));
					if (evt_bus.event_kind !== want_evt.body.event_kind)
						report_mismatch($sformatf("event_kind got %0d want %0d",
							evt_bus.event_kind, want_evt.body.event_kind));
					if (evt_bus.click_total !== want_evt.body.click_total)
						report_mismatch($sformatf("click_total got %0d want %0d",
							evt_bus.click_total, want_evt.body.click_total));
					if (evt_bus.hold_level !== want_evt.body.hold_level)
						report_mismatch($sformatf("hold_level got %0d want %0d",
							evt_bus.hold_level, want_evt.body.hold_level));
					if (evt_bus.last_event !== want_evt.last)
						report_mismatch($sformatf("last_event got %0d want %0d",
							evt_bus.last_event, want_evt.last));
				end
			end
		end
	end

	initial begin
		int          produced;
		int unsigned k;
		req_bus.valid        <= 1'b0;
		req_bus.func         <= FUNC_EDGE;
		req_bus.button_index <= '0;
		req_bus.edge_pressed <= 1'b0;
		req_bus.level_mask   <= '0;
		req_bus.now_ms       <= '0;
		cfg_we               <= 1'b0;
		cfg_index            <= bchd_pkg::CFG_DEBOUNCE;
		cfg_data             <= '0;
		arst_n               <= 1'b0;
		debounce_cfg  = DEBOUNCE_RESET;
		threshold_cfg = THRESHOLD_RESET;
		for (k = 0; k < BUTTONS; k++) begin
			click_tally[k]   = '0;
			hold_tally[k]    = '0;
			press_stamp[k]   = '0;
			release_stamp[k] = '0;
		end

		// func, button, pressed, levels, now, typed count, typed event
		add_row(FUNC_SCAN, 4'd0, 1'b0, 4'b0000, 32'd0, 0, 2'd0, KIND_CLICK, 8'd0, 7'd0);
		add_row(FUNC_SCAN, 4'd0, 1'b0, 4'b1111, 32'd0, 0, 2'd0, KIND_CLICK, 8'd0, 7'd0);
		add_row(FUNC_SCAN, 4'd0, 1'b0, 4'b0001, 32'd500, 1, 2'd0, KIND_HOLD, 8'd0, 7'd0);
		add_row(FUNC_SCAN, 4'd0, 1'b0, 4'b0001, 32'd1000, 1, 2'd0, KIND_HOLD, 8'd0, 7'd1);
		// press then bounce release inside debounce
		add_row(FUNC_EDGE, 4'd1, 1'b1, 4'b0000, 32'd100, 0, 2'd0, KIND_CLICK, 8'd0, 7'd0);
		add_row(FUNC_EDGE, 4'd1, 1'b0, 4'b0000, 32'd110, 0, 2'd0, KIND_CLICK, 8'd0, 7'd0);
		// release with no clicks
		add_row(FUNC_EDGE, 4'd2, 1'b0, 4'b0000, 32'd5, 0, 2'd0, KIND_CLICK, 8'd0, 7'd0);
		// indices past the button count
		add_row(FUNC_EDGE, 4'd15, 1'b1, 4'b1111, 32'hFFFF_FFFF, 0, 2'd0, KIND_CLICK, 8'd0,
			7'd0);
		add_row(FUNC_EDGE, 4'd4, 1'b0, 4'b0000, 32'd0, 0, 2'd0, KIND_CLICK, 8'd0, 7'd0);
		add_row(FUNC_EDGE, 4'd1, 1'b1, 4'b0000, 32'd200, NOT_TYPED, 2'd0, KIND_CLICK, 8'd0,
			7'd0);
		add_row(FUNC_EDGE, 4'd1, 1'b0, 4'b0000, 32'd300, NOT_TYPED, 2'd0, KIND_CLICK, 8'd0,
			7'd0);
		add_row(FUNC_SCAN, 4'd0, 1'b0, 4'b0000, 32'd799, 0, 2'd0, KIND_CLICK, 8'd0, 7'd0);
		add_row(FUNC_SCAN, 4'd0, 1'b0, 4'b0000, 32'd800, 1, 2'd1, KIND_CLICK, 8'd1, 7'd0);
		// press and release across the counter wrap
		add_row(FUNC_EDGE, 4'd3, 1'b1, 4'b0000, 32'hFFFF_FF00, NOT_TYPED, 2'd0, KIND_CLICK,
			8'd0, 7'd0);
		add_row(FUNC_EDGE, 4'd3, 1'b0, 4'b0000, 32'h0000_0010, NOT_TYPED, 2'd0, KIND_CLICK,
			8'd0, 7'd0);
		add_row(FUNC_SCAN, 4'd0, 1'b0, 4'b0000, 32'h0000_0204, 1, 2'd3, KIND_CLICK, 8'd1,
			7'd0);
		add_row(FUNC_EDGE, 4'd0, 1'b1, 4'b0000, 32'd2000, NOT_TYPED, 2'd0, KIND_CLICK, 8'd0,
			7'd0);
		add_row(FUNC_EDGE, 4'd2, 1'b1, 4'b0000, 32'd2000, NOT_TYPED, 2'd0, KIND_CLICK, 8'd0,
			7'd0);
		add_row(FUNC_SCAN, 4'd0, 1'b0, 4'b0101, 32'd2500, NOT_TYPED, 2'd0, KIND_CLICK, 8'd0,
			7'd0);
		add_row(FUNC_EDGE, 4'd1, 1'b1, 4'b0000, 32'd3000, NOT_TYPED, 2'd0, KIND_CLICK, 8'd0,
			7'd0);
		add_row(FUNC_EDGE, 4'd1, 1'b0, 4'b0000, 32'd3040, NOT_TYPED, 2'd0, KIND_CLICK, 8'd0,
			7'd0);
		// release exactly at the debounce limit
		add_row(FUNC_EDGE, 4'd3, 1'b1, 4'b0000, 32'd3000, NOT_TYPED, 2'd0, KIND_CLICK, 8'd0,
			7'd0);
		add_row(FUNC_EDGE, 4'd3, 1'b0, 4'b0000, 32'd3030, NOT_TYPED, 2'd0, KIND_CLICK, 8'd0,
			7'd0);
		add_row(FUNC_SCAN, 4'd0, 1'b0, 4'b1111, 32'hFFFF_FFFF, NOT_TYPED, 2'd0, KIND_CLICK,
			8'd0, 7'd0);
		add_row(FUNC_SCAN, 4'd0, 1'b0, 4'b0000, 32'd0, 0, 2'd0, KIND_CLICK, 8'd0, 7'd0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[r]) begin
			send_req(stim_rows[r].req, produced);
			if (stim_rows[r].typed_count != NOT_TYPED) begin
				if (produced != stim_rows[r].typed_count)
					report_mismatch($sformatf("row %0d: model raised %0d events, table %0d",
						r, produced, stim_rows[r].typed_count));
				else if (produced == 1 &&
						events_due[events_due.size() - 1] !== stim_rows[r].typed_evt)
					report_mismatch($sformatf("row %0d: model event differs from table", r));
			end
			pause_req();
		end

		run_phase(8'd0, 16'd1, 1'b1);
		run_phase(8'hFF, 16'hFFFF, 1'b0);
		run_phase(8'd17, 16'd0, 1'b0);
		run_phase(8'($urandom_range(0, 255)), 16'($urandom_range(20, 400)), 1'b0);
		run_phase(DEBOUNCE_RESET, THRESHOLD_RESET, 1'b0);

		req_bus.valid <= 1'b0;
		while (events_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d edge and %0d scan requests, %0d events checked",
			edges_sent, scans_sent, events_checked);
		$display("%0d register writes, threshold from 0 to 65535, debounce 0 to 255",
			cfg_writes);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
